@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files of this block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/gsfe_pkg.sv @@
`default_nettype none

package gsfe_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int TAG_W = 40;
  localparam logic [TAG_W-1:0] TAG_RESET = 40'h474E474741;

  // Field numbers within a sentence.
  localparam logic [3:0] FIELD_TIME = 4'd1;
  localparam logic [3:0] FIELD_LAT  = 4'd2;
  localparam logic [3:0] FIELD_LON  = 4'd4;
  localparam logic [3:0] COUNT_SAT  = 4'd15;

  localparam int TIME_W  = 25;
  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int TINT_W  = 20;
  localparam int TFRAC_W = 7;
  localparam int WHOLE_W = 10;
  localparam int MIN_W   = 7;
  localparam int N_W     = 27;
  localparam int Q_W     = 25;
  localparam int V_W     = 34;

  localparam logic [TIME_W-1:0] TIME_MAX     = 25'd23595999;
  localparam logic [TINT_W-1:0] TIME_INT_CAP = 20'd1000000;
  localparam logic [LAT_W-1:0]  LAT_MAX      = 30'd900000000;
  localparam logic [LON_W-1:0]  LON_MAX      = 31'd1800000000;
  localparam logic [MIN_W-1:0]  MINUTE_CAP   = 7'd127;

  localparam int DEFAULT_FRACTION_DIGITS = 5;
  localparam int MAX_FRACTION_DIGITS     = 6;
  localparam int FRAC_MAX_W              = 20;
  localparam int FD_MAX_W                = 3;
  localparam int DEFAULT_QUEUE_DEPTH     = 4;

  // Reciprocal of three, exact for dividends below 2^32 with a shift of 33.
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAAAAAB;
  localparam int DIV3_SHIFT = 33;

  typedef enum logic [1:0] {
    FLD_NONE,
    FLD_TIME,
    FLD_LAT,
    FLD_LON
  } fld_kind_t;

  // One closed field (or the end of a sentence) as handed to the back end.
  typedef struct packed {
    fld_kind_t                 kind;
    logic                      last;
    logic                      emit;
    logic                      ok;
    logic [WHOLE_W-1:0]        whole;
    logic [MIN_W-1:0]          minute;
    logic [FRAC_MAX_W-1:0]     frac;
    logic [FD_MAX_W-1:0]       frac_digits;
    logic [TINT_W-1:0]         time_int;
    logic [TFRAC_W-1:0]        time_frac;
    logic [1:0]                time_digits;
  } rec_t;

  function automatic logic [23:0] pow10(input logic [2:0] k);
    logic [23:0] r;
    case (k)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/gsfe_queue.sv @@
`default_nettype none

`include "assert_macros.svh"

module gsfe_queue import gsfe_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t din,
  output logic      full,
  input  wire logic pop,
  output rec_t      dout,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_push_has_room, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_pop_has_word, clk, rst, pop, !empty)
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ src/gsfe_front.sv @@
`default_nettype none

module gsfe_front import gsfe_pkg::*; #(
  parameter int MINUTE_FRACTION_DIGITS = DEFAULT_FRACTION_DIGITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic [TAG_W-1:0] sentence_tag,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             q_full,
  output logic                  q_push,
  output rec_t                  q_rec
);

  localparam int FRAC_W = $clog2(pow10(3'(MINUTE_FRACTION_DIGITS)));
  localparam int FD_W   = $clog2(MINUTE_FRACTION_DIGITS + 1);

  logic [TAG_W-1:0]   tag_reg;
  logic               in_sentence, in_sentence_next;
  logic [TAG_W-1:0]   tag_window, tag_window_next;
  logic               tag_seen, tag_seen_next;
  logic [3:0]         field_index, field_index_next;
  logic [3:0]         char_in_field, char_in_field_next;
  logic               field_ok, field_ok_next;
  logic               after_point, after_point_next;
  logic [FD_W-1:0]    frac_digits, frac_digits_next;
  logic [FRAC_W-1:0]  frac, frac_next;
  logic [WHOLE_W-1:0] whole, whole_next;
  logic [MIN_W-1:0]   minute, minute_next;
  logic [TINT_W-1:0]  time_int, time_int_next;
  logic [TFRAC_W-1:0] time_frac, time_frac_next;
  logic [1:0]         time_digits, time_digits_next;

  logic               accept;
  logic               is_digit;
  logic [3:0]         digit;
  logic [TAG_W-1:0]   window_eff;
  logic               seen_eff;
  fld_kind_t          kind;
  logic [3:0]         deg_digits;
  logic               push_req;
  logic               is_last;
  logic               clear_fld;
  logic [23:0]        time_ext;
  logic [10:0]        minute_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = rx_byte[3:0];

  // The window restarts at the dollar sign, which is the first byte shifted in.
  assign window_eff = in_sentence ? {tag_window[TAG_W-9:0], rx_byte}
                                  : {{(TAG_W-8){1'b0}}, rx_byte};
  assign seen_eff   = (in_sentence && tag_seen) || (window_eff == tag_reg);

  always_comb begin
    case (field_index)
      FIELD_TIME: kind = FLD_TIME;
      FIELD_LAT:  kind = FLD_LAT;
      FIELD_LON:  kind = FLD_LON;
      default:    kind = FLD_NONE;
    endcase
  end

  assign deg_digits = (kind == FLD_LAT) ? 4'd2 : 4'd3;
  assign time_ext   = 24'(time_int) * 24'd10 + 24'(digit);
  assign minute_ext = 11'(minute) * 11'd10 + 11'(digit);

  // Record for the field being closed, built from the state before this byte.
  always_comb begin
    q_rec             = '0;
    q_rec.kind        = kind;
    q_rec.last        = is_last;
    q_rec.emit        = seen_eff;
    q_rec.whole       = whole;
    q_rec.minute      = minute;
    q_rec.frac        = FRAC_MAX_W'(frac);
    q_rec.frac_digits = FD_MAX_W'(frac_digits);
    q_rec.time_int    = time_int;
    q_rec.time_frac   = time_frac;
    q_rec.time_digits = time_digits;
    if (kind == FLD_TIME) begin
      q_rec.ok = field_ok && (char_in_field != 4'(after_point));
    end else begin
      q_rec.ok = field_ok && (char_in_field >= deg_digits + 4'd1 + 4'(after_point));
    end
  end

  assign q_push = accept && push_req;

  always_comb begin
    in_sentence_next   = in_sentence;
    tag_window_next    = tag_window;
    tag_seen_next      = tag_seen;
    field_index_next   = field_index;
    char_in_field_next = char_in_field;
    field_ok_next      = field_ok;
    after_point_next   = after_point;
    frac_digits_next   = frac_digits;
    frac_next          = frac;
    whole_next         = whole;
    minute_next        = minute;
    time_int_next      = time_int;
    time_frac_next     = time_frac;
    time_digits_next   = time_digits;
    push_req           = 1'b0;
    is_last            = 1'b0;
    clear_fld          = 1'b0;

    if (in_sentence) begin
      tag_window_next = window_eff;
      tag_seen_next   = seen_eff;
      if (rx_byte == CH_LF) begin
        push_req         = 1'b1;
        is_last          = 1'b1;
        in_sentence_next = 1'b0;
      end else if (rx_byte == CH_COMMA) begin
        push_req  = (kind != FLD_NONE);
        clear_fld = 1'b1;
        if (field_index != COUNT_SAT) begin
          field_index_next = field_index + 4'd1;
        end
      end else if (rx_byte != CH_CR && kind != FLD_NONE) begin
        if (char_in_field != COUNT_SAT) begin
          char_in_field_next = char_in_field + 4'd1;
        end
        if (kind == FLD_TIME) begin
          if (is_digit && !after_point) begin
            time_int_next = (time_int >= TIME_INT_CAP || time_ext > 24'(TIME_INT_CAP))
                          ? TIME_INT_CAP : TINT_W'(time_ext);
          end else if (is_digit) begin
            if (time_digits < 2'd2) begin
              time_frac_next   = TFRAC_W'(time_frac * 7'd10 + 7'(digit));
              time_digits_next = time_digits + 2'd1;
            end
          end else if (rx_byte == CH_POINT && !after_point) begin
            after_point_next = 1'b1;
          end else begin
            field_ok_next = 1'b0;
          end
        end else begin
          if (char_in_field < deg_digits) begin
            if (is_digit) begin
              whole_next = WHOLE_W'(whole * 10'd10 + 10'(digit));
            end else begin
              field_ok_next = 1'b0;
            end
          end else if (is_digit && !after_point) begin
            minute_next = (minute_ext > 11'(MINUTE_CAP)) ? MINUTE_CAP : MIN_W'(minute_ext);
          end else if (is_digit) begin
            if (frac_digits < FD_W'(MINUTE_FRACTION_DIGITS)) begin
              frac_next        = FRAC_W'(frac * FRAC_W'(10) + FRAC_W'(digit));
              frac_digits_next = frac_digits + 1'b1;
            end
          end else if (rx_byte == CH_POINT && !after_point) begin
            after_point_next = 1'b1;
          end else begin
            field_ok_next = 1'b0;
          end
        end
      end
    end else if (rx_byte == CH_DOLLAR) begin
      in_sentence_next = 1'b1;
      tag_window_next  = window_eff;
      tag_seen_next    = seen_eff;
      field_index_next = '0;
      time_int_next    = '0;
      clear_fld        = 1'b1;
    end

    if (clear_fld) begin
      char_in_field_next = '0;
      field_ok_next      = 1'b1;
      after_point_next   = 1'b0;
      frac_digits_next   = '0;
      frac_next          = '0;
      whole_next         = '0;
      minute_next        = '0;
      time_frac_next     = '0;
      time_digits_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_reg       <= TAG_RESET;
      in_sentence   <= 1'b0;
      tag_window    <= '0;
      tag_seen      <= 1'b0;
      field_index   <= '0;
      char_in_field <= '0;
      field_ok      <= 1'b0;
      after_point   <= 1'b0;
      frac_digits   <= '0;
      frac          <= '0;
      whole         <= '0;
      minute        <= '0;
      time_int      <= '0;
      time_frac     <= '0;
      time_digits   <= '0;
    end else begin
      if (cfg_valid) begin
        tag_reg <= sentence_tag;
      end
      if (accept) begin
        in_sentence   <= in_sentence_next;
        tag_window    <= tag_window_next;
        tag_seen      <= tag_seen_next;
        field_index   <= field_index_next;
        char_in_field <= char_in_field_next;
        field_ok      <= field_ok_next;
        after_point   <= after_point_next;
        frac_digits   <= frac_digits_next;
        frac          <= frac_next;
        whole         <= whole_next;
        minute        <= minute_next;
        time_int      <= time_int_next;
        time_frac     <= time_frac_next;
        time_digits   <= time_digits_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/gsfe_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module gsfe_back import gsfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rec_t        q_head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             fix_valid,
  output logic [TIME_W-1:0] utc_centi,
  output logic [LAT_W-1:0]  lat_e7,
  output logic [LON_W-1:0]  lon_e7
);

  localparam logic [N_W-1:0] MEG = N_W'(1000000);
  localparam logic [V_W-1:0] E7  = V_W'(10000000);
  localparam int PROD_W = (N_W - 1) + 32;

  // Stage A: minutes scaled to millionths, degrees scaled, time finished.
  logic              a_valid;
  fld_kind_t         a_kind;
  logic              a_last, a_emit, a_ok;
  logic [N_W-1:0]    a_n;
  logic [V_W-1:0]    a_whole_e7;
  logic [TIME_W-1:0] a_time;
  // Stage B: minutes divided by sixty (in units of 1e-7 degree).
  logic              b_valid;
  fld_kind_t         b_kind;
  logic              b_last, b_emit, b_ok;
  logic [Q_W-1:0]    b_q;
  logic [V_W-1:0]    b_whole_e7;
  logic [TIME_W-1:0] b_time;
  // Running sentence results.
  logic [TIME_W-1:0] time_val, time_nx;
  logic [LAT_W-1:0]  lat_val, lat_nx;
  logic [LON_W-1:0]  lon_val, lon_nx;

  logic              adv;
  logic              commit;
  logic [43:0]       frac_scaled;
  logic [N_W-1:0]    n_calc;
  logic [9:0]        tfrac_calc;
  logic [N_W-1:0]    t100;
  logic [TIME_W-1:0] time_calc;
  logic [PROD_W-1:0] prod;
  logic [V_W-1:0]    v_sum;
  logic [LAT_W-1:0]  lat_sat;
  logic [LON_W-1:0]  lon_sat;
  logic              out_in_range;

  // The whole pipe holds only while a finished sentence waits on a full output.
  assign adv    = !(b_valid && b_last && b_emit && out_valid && !out_ready);
  assign q_pop  = adv && !q_empty;
  assign commit = adv && b_valid;

  // minutes * 1e6 = minute * 1e6 + frac * 10^(6 - digits)
  assign frac_scaled = 44'(q_head.frac)
                     * 44'(pow10(3'(MAX_FRACTION_DIGITS) - q_head.frac_digits));
  assign n_calc      = N_W'(q_head.minute) * MEG + N_W'(frac_scaled);

  assign tfrac_calc = (q_head.time_digits == 2'd1) ? 10'(q_head.time_frac) * 10'd10
                                                   : 10'(q_head.time_frac);
  assign t100       = N_W'(q_head.time_int) * N_W'(100) + N_W'(tfrac_calc);

  always_comb begin
    if (!q_head.ok) begin
      time_calc = '0;
    end else if (q_head.time_int >= TIME_INT_CAP || t100 > N_W'(TIME_MAX)) begin
      time_calc = TIME_MAX;
    end else begin
      time_calc = TIME_W'(t100);
    end
  end

  // floor(n / 6) = floor(floor(n / 2) / 3)
  assign prod = PROD_W'(a_n[N_W-1:1]) * PROD_W'(DIV3_MAGIC);

  assign v_sum   = b_whole_e7 + V_W'(b_q);
  assign lat_sat = (v_sum > V_W'(LAT_MAX)) ? LAT_MAX : LAT_W'(v_sum);
  assign lon_sat = (v_sum > V_W'(LON_MAX)) ? LON_MAX : LON_W'(v_sum);

  always_comb begin
    time_nx = time_val;
    lat_nx  = lat_val;
    lon_nx  = lon_val;
    case (b_kind)
      FLD_TIME: time_nx = b_time;
      FLD_LAT:  lat_nx  = b_ok ? lat_sat : '0;
      FLD_LON:  lon_nx  = b_ok ? lon_sat : '0;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind     <= q_head.kind;
      a_last     <= q_head.last;
      a_emit     <= q_head.emit;
      a_ok       <= q_head.ok;
      a_n        <= n_calc;
      a_whole_e7 <= V_W'(q_head.whole) * E7;
      a_time     <= time_calc;
      b_kind     <= a_kind;
      b_last     <= a_last;
      b_emit     <= a_emit;
      b_ok       <= a_ok;
      b_q        <= prod[DIV3_SHIFT +: Q_W];
      b_whole_e7 <= a_whole_e7;
      b_time     <= a_time;
    end
    if (commit && b_last && b_emit) begin
      fix_valid <= (lat_nx != '0) && (lon_nx != '0);
      utc_centi <= time_nx;
      lat_e7    <= lat_nx;
      lon_e7    <= lon_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      time_val  <= '0;
      lat_val   <= '0;
      lon_val   <= '0;
    end else begin
      if (adv) begin
        a_valid <= !q_empty;
        b_valid <= a_valid;
      end
      if (commit) begin
        if (b_last) begin
          time_val <= '0;
          lat_val  <= '0;
          lon_val  <= '0;
        end else begin
          time_val <= time_nx;
          lat_val  <= lat_nx;
          lon_val  <= lon_nx;
        end
      end
      if (commit && b_last && b_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_in_range = (utc_centi <= TIME_MAX) && (lat_e7 <= LAT_MAX) && (lon_e7 <= LON_MAX);

  `ASSERT_IMPLIES(a_fix_flag, clk, rst, out_valid, fix_valid == ((lat_e7 != '0) && (lon_e7 != '0)))
  `ASSERT_IMPLIES(a_out_range, clk, rst, out_valid, out_in_range)
  `ASSERT_IMPLIES(a_hold_stage, clk, rst, !adv, b_valid && b_last && b_emit)

endmodule

`default_nettype wire

@@ src/gga_sentence_field_extractor.sv @@
// Channel   Dir  Handshake             Payload
// config    in   cfg_valid/cfg_ready   sentence_tag[39:0]
// input     in   in_valid/in_ready     rx_byte[7:0]
// result    out  out_valid/out_ready   fix_valid, utc_centi, lat_e7, lon_e7
//
// One byte is taken per cycle for as long as the result side keeps up.
// A result reaches the output register after its line feed is taken by way
// of the field queue, then the scaling stage and the divide-by-sixty
// multiplier stage, before the commit into the output.
// Reset is synchronous; there is no clearing pass.
// in_ready falls only when the field queue fills, which, with a QUEUE_DEPTH
// above one, can happen only while a finished result waits on a low out_ready.
`default_nettype none

module gga_sentence_field_extractor import gsfe_pkg::*; #(
  parameter int MINUTE_FRACTION_DIGITS = DEFAULT_FRACTION_DIGITS,
  parameter int QUEUE_DEPTH            = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TAG_W-1:0]  sentence_tag,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   fix_valid,
  output logic [TIME_W-1:0]      utc_centi,
  output logic [LAT_W-1:0]       lat_e7,
  output logic [LON_W-1:0]       lon_e7
);

  // The tag register is written whenever cfg_valid is high, so the config port never
  // pushes back.
  assign cfg_ready = 1'b1;

  // Words crossing from the byte parser to the arithmetic side: one per
  // closed time, latitude or longitude field, plus one per line feed that ends a sentence.
  rec_t push_rec;
  rec_t head_rec;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Front end: sentence framing, tag match and digit accumulation.
  gsfe_front #(
    .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .sentence_tag(sentence_tag),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (push_rec)
  );

  // Short queue so the parser keeps taking bytes while the result waits.
  gsfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (push_rec),
    .full (q_full),
    .pop  (q_pop),
    .dout (head_rec),
    .empty(q_empty)
  );

  // Back end: degree conversion, saturation and the output register.
  gsfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (head_rec),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fix_valid(fix_valid),
    .utc_centi(utc_centi),
    .lat_e7   (lat_e7),
    .lon_e7   (lon_e7)
  );

endmodule

`default_nettype wire
